[hdl/mp2d_pkg.sv]
// ----------------------------------------------------------------------------
// Max pooling stream package
// Shared constants, default parameter values and register indexes for the
// streaming two-dimensional max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  // Default values of the top level parameters.
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned MAX_WINDOW_DEF  = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed widths of the configuration and result fields.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_CFG_W  = 11;
  localparam int unsigned WIN_CFG_W  = 4;
  localparam int unsigned OUT_IDX_W  = 10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_WINDOW_HEIGHT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_STEP_DOWN     = 3'd4,
    REG_STEP_ACROSS   = 3'd5
  } cfg_reg_e;

endpackage

[hdl/mp2d_sample_if.sv]
// ----------------------------------------------------------------------------
// Sample stream interface
// Valid/ready channel that carries one feature map sample per transaction.
// ----------------------------------------------------------------------------
interface mp2d_sample_if #(
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[hdl/mp2d_result_if.sv]
// ----------------------------------------------------------------------------
// Pooled result interface
// Valid/ready channel that carries one window maximum with its output
// position and the end-of-frame flag per transaction.
// ----------------------------------------------------------------------------
interface mp2d_result_if #(
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
);
  import mp2d_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic [OUT_IDX_W-1:0]          out_row;
  logic [OUT_IDX_W-1:0]          out_col;
  logic                          last_of_frame;

  modport source (output valid, output pooled_value, output out_row, output out_col,
                  output last_of_frame, input ready);
  modport sink   (input valid, input pooled_value, input out_row, input out_col,
                  input last_of_frame, output ready);
endinterface

[hdl/mp2d_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready channel that writes one configuration register per transaction.
// ----------------------------------------------------------------------------
interface mp2d_cfg_if;
  import mp2d_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/mp2d_line_mem.sv]
// ----------------------------------------------------------------------------
// Line store row memory
// Holds one earlier row of samples. One write port and one read port; the
// read data is registered and returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module mp2d_line_mem #(
  parameter int unsigned DATA_W = mp2d_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DEPTH  = mp2d_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[hdl/max_pool_2d_stream_core.sv]
// A result passes the stage 1, stage 2 and output registers after the sample that ends its window.
// Throughput: one sample per cycle unless the output stalls; all rows read, one written per sample.
// Each row memory has one read and one write port, which sets the one-sample-per-cycle rate.
// Reset restores default registers, clears the position counters and sets column maxima to MOST_NEG.
// The line store is not cleared; every entry is written before its read data is used.
// ----------------------------------------------------------------------------
// Streaming max pooling core
// Takes samples of one channel in raster order, keeps earlier rows in a line
// store and emits the maximum of every window that lies on the stride grid.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_core #(
  parameter int unsigned MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_WINDOW  = mp2d_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mp2d_sample_if.sink   sample_i,
  mp2d_result_if.source result_o,
  mp2d_cfg_if.sink      cfg_i
);
  import mp2d_pkg::*;

  localparam int unsigned LINE_ROWS = MAX_WINDOW - 1;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned DIM_W     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DIM_EXT_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
  localparam int unsigned WIN_W     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WIN_EXT_W = (WIN_W > WIN_CFG_W) ? WIN_W : WIN_CFG_W;
  localparam int unsigned SLOT_W    = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Clamp helpers: zero acts as one, oversize acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
    logic [DIM_EXT_W-1:0] e;
    e = DIM_EXT_W'(v);
    if (e == '0) return DIM_W'(1);
    if (e > DIM_EXT_W'(MAX_WIDTH)) return DIM_W'(MAX_WIDTH);
    return DIM_W'(e);
  endfunction

  function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_CFG_W-1:0] v);
    logic [WIN_EXT_W-1:0] e;
    e = WIN_EXT_W'(v);
    if (e == '0) return WIN_W'(1);
    if (e > WIN_EXT_W'(MAX_WINDOW)) return WIN_W'(MAX_WINDOW);
    return WIN_W'(e);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_CFG_W-1:0] frame_width_q, frame_height_q;
  logic [WIN_CFG_W-1:0] window_height_q, window_width_q, step_down_q, step_across_q;
  logic                 cfg_hit;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_reg_e'(cfg_i.index))
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_WINDOW_HEIGHT,
      REG_WINDOW_WIDTH, REG_STEP_DOWN, REG_STEP_ACROSS: cfg_hit = cfg_i.valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= DIM_CFG_W'(1);
      frame_height_q  <= DIM_CFG_W'(1);
      window_height_q <= WIN_CFG_W'(2);
      window_width_q  <= WIN_CFG_W'(2);
      step_down_q     <= WIN_CFG_W'(2);
      step_across_q   <= WIN_CFG_W'(2);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FRAME_WIDTH:   frame_width_q   <= cfg_i.data[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_q  <= cfg_i.data[DIM_CFG_W-1:0];
        REG_WINDOW_HEIGHT: window_height_q <= cfg_i.data[WIN_CFG_W-1:0];
        REG_WINDOW_WIDTH:  window_width_q  <= cfg_i.data[WIN_CFG_W-1:0];
        REG_STEP_DOWN:     step_down_q     <= cfg_i.data[WIN_CFG_W-1:0];
        REG_STEP_ACROSS:   step_across_q   <= cfg_i.data[WIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping.
  logic [DIM_W-1:0] fw, fh;
  logic [WIN_W-1:0] wh, ww, sd, sa;

  assign fw = clamp_dim(frame_width_q);
  assign fh = clamp_dim(frame_height_q);
  assign wh = clamp_win(window_height_q);
  assign ww = clamp_win(window_width_q);
  assign sd = clamp_win(step_down_q);
  assign sa = clamp_win(step_across_q);

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register is free.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic accept;

  assign adv            = !out_valid_q || result_o.ready;
  assign sample_i.ready = adv;
  assign accept         = sample_i.valid && adv;

  // --------------------------------------------------------------------------
  // Position counters. The phase counters track the window origin modulo the
  // stride, the output counters the origin divided by the stride.
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  row_q, row_d, col_q, col_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [WIN_W-1:0]  rph_q, rph_d, cph_q, cph_d;
  logic [COL_W-1:0]  orow_q, orow_d, ocol_q, ocol_d;
  logic              row_fit, col_fit, col_end, row_end, emit, last;

  always_comb begin
    row_fit = (32'(row_q) + 32'd1) >= 32'(wh);
    col_fit = (32'(col_q) + 32'd1) >= 32'(ww);
    col_end = (32'(col_q) + 32'd1) >= 32'(fw);
    row_end = (32'(row_q) + 32'd1) >= 32'(fh);
    emit    = row_fit && col_fit && (rph_q == '0) && (cph_q == '0);
    // The last origin on each axis is the one whose next step no longer fits.
    last    = ((32'(row_q) + 32'(sd)) >= 32'(fh)) && ((32'(col_q) + 32'(sa)) >= 32'(fw));
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    rph_d  = rph_q;
    cph_d  = cph_q;
    orow_d = orow_q;
    ocol_d = ocol_q;
    if (cfg_hit) begin
      row_d  = '0;
      col_d  = '0;
      slot_d = '0;
      rph_d  = '0;
      cph_d  = '0;
      orow_d = '0;
      ocol_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        cph_d = '0;
        ocol_d = '0;
        if (row_end) begin
          row_d  = '0;
          slot_d = '0;
          rph_d  = '0;
          orow_d = '0;
        end else begin
          row_d  = row_q + COL_W'(1);
          slot_d = (32'(slot_q) == LINE_ROWS - 1) ? '0 : slot_q + SLOT_W'(1);
          if (row_fit) begin
            if ((32'(rph_q) + 32'd1) == 32'(sd)) begin
              rph_d  = '0;
              orow_d = orow_q + COL_W'(1);
            end else begin
              rph_d = rph_q + WIN_W'(1);
            end
          end
        end
      end else begin
        col_d = col_q + COL_W'(1);
        if (col_fit) begin
          if ((32'(cph_q) + 32'd1) == 32'(sa)) begin
            cph_d  = '0;
            ocol_d = ocol_q + COL_W'(1);
          end else begin
            cph_d = cph_q + WIN_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
      rph_q  <= '0;
      cph_q  <= '0;
      orow_q <= '0;
      ocol_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
      rph_q  <= rph_d;
      cph_q  <= cph_d;
      orow_q <= orow_d;
      ocol_q <= ocol_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one memory per earlier row. A row's age is its distance above
  // the current row; it joins the column maximum when it lies in the window.
  // --------------------------------------------------------------------------
  logic [LINE_ROWS-1:0]   use_d;
  logic [SAMPLE_BITS-1:0] rd_data [LINE_ROWS];

  always_comb begin
    int age;
    for (int m = 0; m < LINE_ROWS; m++) begin
      if (32'(slot_q) == m) begin
        age = LINE_ROWS;
      end else if (32'(slot_q) > m) begin
        age = 32'(slot_q) - m;
      end else begin
        age = 32'(slot_q) + LINE_ROWS - m;
      end
      use_d[m] = row_fit && (age < 32'(wh));
    end
  end

  for (genvar m = 0; m < LINE_ROWS; m++) begin : g_row
    mp2d_line_mem #(
      .DATA_W (SAMPLE_BITS),
      .DEPTH  (MAX_WIDTH)
    ) u_row_mem (
      .clk_i   (clk_i),
      .we_i    (accept && (32'(slot_q) == m)),
      .waddr_i (col_q),
      .wdata_i (sample_i.sample),
      .re_i    (accept),
      .raddr_i (col_q),
      .rdata_o (rd_data[m])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 1: sample and window flags, column maximum over the window rows.
  // --------------------------------------------------------------------------
  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                          s1_emit_q, s1_last_q;
  logic [COL_W-1:0]              s1_orow_q, s1_ocol_q;
  logic [LINE_ROWS-1:0]          s1_use_q;
  logic signed [SAMPLE_BITS-1:0] colmax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i.sample;
      s1_emit_q   <= emit;
      s1_last_q   <= last;
      s1_orow_q   <= orow_q;
      s1_ocol_q   <= ocol_q;
      s1_use_q    <= use_d;
    end
  end

  always_comb begin
    colmax = s1_sample_q;
    for (int m = 0; m < LINE_ROWS; m++) begin
      if (s1_use_q[m] && ($signed(rd_data[m]) > colmax)) begin
        colmax = $signed(rd_data[m]);
      end
    end
  end

  // Column maxima of the most recent samples, newest first.
  logic signed [SAMPLE_BITS-1:0] colmax_q [MAX_WINDOW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        colmax_q[k] <= MOST_NEG;
      end
    end else if (adv && s1_valid_q) begin
      colmax_q[0] <= colmax;
      for (int k = 1; k < MAX_WINDOW; k++) begin
        colmax_q[k] <= colmax_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: window maximum over the newest window_width column maxima.
  // --------------------------------------------------------------------------
  logic                          s2_valid_q;
  logic                          s2_last_q;
  logic [COL_W-1:0]              s2_orow_q, s2_ocol_q;
  logic signed [SAMPLE_BITS-1:0] winmax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_last_q <= s1_last_q;
      s2_orow_q <= s1_orow_q;
      s2_ocol_q <= s1_ocol_q;
    end
  end

  always_comb begin
    winmax = colmax_q[0];
    for (int k = 1; k < MAX_WINDOW; k++) begin
      if ((k < 32'(ww)) && (colmax_q[k] > winmax)) begin
        winmax = colmax_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [OUT_IDX_W-1:0]          out_row_q, out_col_q;
  logic                          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_value_q <= winmax;
      out_row_q   <= OUT_IDX_W'(s2_orow_q);
      out_col_q   <= OUT_IDX_W'(s2_ocol_q);
      out_last_q  <= s2_last_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.pooled_value  = out_value_q;
  assign result_o.out_row       = out_row_q;
  assign result_o.out_col       = out_col_q;
  assign result_o.last_of_frame = out_last_q;

endmodule
